>>> rtl/mtf_pkg.sv
// Shared types and constants of the move-to-front list.
// Used by mtf_cell, mtf_ctrl and move_to_front_list; depends on nothing.
`timescale 1ns / 1ps

package mtf_pkg;

   // Fixed field widths of the channels
   localparam int FIELD_BITS = 16;
   localparam int KIND_BITS  = 2;
   localparam int OCC_BITS   = 7;

   // Default sizing of the list
   localparam int MTF_CAPACITY   = 64;
   localparam int MTF_VALUE_BITS = 16;

   // Item kinds on the request channel
   localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ACCESS  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DUMP    = 2'd2;

   // What every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INIT,
      CELL_CAPTURE,
      CELL_SHIFT,
      CELL_ROTATE
   } cell_op_type;

   // Broadcast from the controller to the row of cells
   typedef struct packed {
      cell_op_type           op;
      logic [OCC_BITS-1:0]   occ;
   } cell_ctrl_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_DUMP
   } ctrl_state_type;

endpackage

>>> rtl/mtf_cell.sv
// One list position: holds a value, compares it against the accessed key,
// and shifts or rotates with its neighbors. Depends on mtf_pkg.
`timescale 1ns / 1ps

module mtf_cell #(
   parameter int VALUE_BITS = mtf_pkg::MTF_VALUE_BITS,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  mtf_pkg::cell_ctrl_type  ctrl,
   input  logic [VALUE_BITS-1:0]   key,
   input  logic [VALUE_BITS-1:0]   left_value,
   input  logic [VALUE_BITS-1:0]   right_value,
   input  logic [VALUE_BITS-1:0]   front_value,
   input  logic                    hit_in,
   output logic                    hit_out,
   output logic [VALUE_BITS-1:0]   value
);
   import mtf_pkg::*;

   localparam logic [OCC_BITS-1:0] POS      = OCC_BITS'(INDEX);
   localparam logic [OCC_BITS-1:0] POS_NEXT = OCC_BITS'(INDEX + 1);

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  match_ff, match_in;
   logic                  is_valid, in_range, is_tail;

   // Position relative to the current occupancy
   assign is_valid = POS < ctrl.occ;
   assign in_range = POS <= ctrl.occ;
   assign is_tail  = POS_NEXT == ctrl.occ;

   // Hit chain: set once this cell or any earlier cell matched
   assign hit_out = hit_in | match_ff;
   assign value   = value_ff;

   // Next value and match flag
   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (ctrl.op)
         CELL_INIT: begin
            value_in = VALUE_BITS'(INDEX + 1);
         end
         CELL_CAPTURE: begin
            match_in = is_valid && (value_ff == key);
         end
         CELL_SHIFT: begin
            // cells up to the removed (or new) position move back one
            if (!hit_in && in_range) begin
               value_in = left_value;
            end
         end
         CELL_ROTATE: begin
            // front goes to the tail, the rest move forward
            if (is_valid) begin
               value_in = is_tail ? front_value : right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

endmodule

>>> rtl/mtf_ctrl.sv
// Sequencer of the move-to-front list: handshakes, occupancy, dump counter,
// register and result output stage. Depends on mtf_pkg.
`timescale 1ns / 1ps

module mtf_ctrl #(
   parameter int CAPACITY = mtf_pkg::MTF_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mtf_pkg::KIND_BITS-1:0]     req_kind,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mtf_pkg::OCC_BITS-1:0]      csr_data,
   input  logic                              found_in,
   input  logic [mtf_pkg::FIELD_BITS-1:0]    key_field,
   input  logic [mtf_pkg::FIELD_BITS-1:0]    front_field,
   output mtf_pkg::cell_ctrl_type            cell_ctrl,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mtf_pkg::FIELD_BITS-1:0]    rsp_entry,
   output logic                              rsp_is_last,
   output logic                              rsp_found,
   output logic                              rsp_dropped,
   output logic                              rsp_list_empty
);
   import mtf_pkg::*;

   localparam logic [OCC_BITS-1:0] CAP_OCC = OCC_BITS'(CAPACITY);

   ctrl_state_type          state_ff, state_in;
   logic [OCC_BITS-1:0]     occ_ff, occ_in;
   logic [OCC_BITS-1:0]     init_count_ff, init_count_in;
   logic [OCC_BITS-1:0]     count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]   rsp_entry_ff, rsp_entry_in;
   logic                    rsp_is_last_ff, rsp_is_last_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_dropped_ff, rsp_dropped_in;
   logic                    rsp_list_empty_ff, rsp_list_empty_in;
   logic                    out_free, load_rsp, dump_last, drop;
   cell_op_type             op;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dump_last = (count_ff + OCC_BITS'(1)) == occ_ff;
   assign drop      = !found_in && (occ_ff == CAP_OCC);
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_ACCESS: state_in = ST_ACCESS;
                  KIND_DUMP:   state_in = ST_DUMP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free && (occ_ff == '0 || dump_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs per state: cell command, request ready, result contents
   always_comb begin
      req_ready         = 1'b0;
      op                = CELL_HOLD;
      load_rsp          = 1'b0;
      rsp_entry_in      = rsp_entry_ff;
      rsp_is_last_in    = 1'b1;
      rsp_found_in      = 1'b0;
      rsp_dropped_in    = 1'b0;
      rsp_list_empty_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_kind)
                  KIND_RESTART: op = CELL_INIT;
                  KIND_ACCESS:  op = CELL_CAPTURE;
                  default:      op = CELL_HOLD;
               endcase
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               load_rsp       = 1'b1;
               op             = drop ? CELL_HOLD : CELL_SHIFT;
               rsp_entry_in   = key_field;
               rsp_found_in   = found_in;
               rsp_dropped_in = drop;
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (occ_ff == '0) begin
                  rsp_entry_in      = '0;
                  rsp_list_empty_in = 1'b1;
               end else begin
                  op             = CELL_ROTATE;
                  rsp_entry_in   = front_field;
                  rsp_is_last_in = dump_last;
               end
            end
         end
         default: begin
            op = CELL_HOLD;
         end
      endcase
   end

   assign cell_ctrl.op  = op;
   assign cell_ctrl.occ = occ_ff;

   // Occupancy, dump counter, register and output valid
   always_comb begin
      occ_in        = occ_ff;
      count_in      = count_ff;
      init_count_in = init_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (csr_valid) begin
         init_count_in = csr_data;
      end
      if (op == CELL_INIT) begin
         occ_in = (init_count_ff > CAP_OCC) ? CAP_OCC : init_count_ff;
      end
      if (state_ff == ST_ACCESS && load_rsp && !found_in && !drop) begin
         occ_in = occ_ff + OCC_BITS'(1);
      end
      if (state_ff == ST_IDLE) begin
         count_in = '0;
      end else if (state_ff == ST_DUMP && load_rsp) begin
         count_in = count_ff + OCC_BITS'(1);
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         init_count_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         init_count_ff <= init_count_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_entry_ff      <= rsp_entry_in;
         rsp_is_last_ff    <= rsp_is_last_in;
         rsp_found_ff      <= rsp_found_in;
         rsp_dropped_ff    <= rsp_dropped_in;
         rsp_list_empty_ff <= rsp_list_empty_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_entry      = rsp_entry_ff;
   assign rsp_is_last    = rsp_is_last_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_list_empty = rsp_list_empty_ff;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP_OCC)
      else $error("occupancy above capacity");

   a_found_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_dropped_ff))
      else $error("access both found and dropped");

   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && occ_ff != '0) |-> count_ff < occ_ff)
      else $error("dump counter past occupancy");

   a_dump_occ: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |=> $stable(occ_ff))
      else $error("occupancy changed during dump");

endmodule

>>> rtl/move_to_front_list.sv
// Top level of the move-to-front list: a row of mtf_cell positions driven by
// mtf_ctrl. Depends on mtf_pkg, mtf_cell and mtf_ctrl.
//
// Usage:
//   Request channel (req_valid/req_ready, req_kind, req_value) takes one item
//   at a time. Kind restart fills positions with 1..initial_count (saturated
//   at CAPACITY) in the accept cycle and answers nothing. Kind access compares
//   all positions at accept, then, once the output is free, moves the value
//   to the front (inserting a miss, dropping it if the list is full) and
//   loads one acknowledgement. Kind dump rotates the row one position per
//   cycle while the output is free, gives one item per entry, front first,
//   is_last on the final one, and holds requests off; an empty list gives
//   one item with list_empty set. Kind 3 is taken and ignored.
//   Results leave through one output register; while a result is held and
//   rsp_ready is low the sequencer waits and the row holds. A restart or
//   unused item can still be taken while an earlier result waits.
//   The csr port (csr_valid/csr_ready, csr_data) writes initial_count; it is
//   always ready. Reset empties the list and clears initial_count; stored
//   values are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps

module move_to_front_list #(
   parameter int CAPACITY   = mtf_pkg::MTF_CAPACITY,
   parameter int VALUE_BITS = mtf_pkg::MTF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mtf_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [mtf_pkg::FIELD_BITS-1:0]    req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mtf_pkg::FIELD_BITS-1:0]    rsp_entry,
   output logic                              rsp_is_last,
   output logic                              rsp_found,
   output logic                              rsp_dropped,
   output logic                              rsp_list_empty,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mtf_pkg::OCC_BITS-1:0]      csr_data
);
   import mtf_pkg::*;

   cell_ctrl_type          cell_ctrl;
   logic [VALUE_BITS-1:0]  req_key;
   logic [VALUE_BITS-1:0]  key_ff;
   logic [VALUE_BITS-1:0]  cell_value [CAPACITY];
   logic                   hit [CAPACITY+1];
   logic [FIELD_BITS-1:0]  key_field, front_field;

   // Value masked to the stored width
   assign req_key     = VALUE_BITS'(req_value);
   assign key_field   = FIELD_BITS'(key_ff);
   assign front_field = FIELD_BITS'(cell_value[0]);
   assign hit[0]      = 1'b0;

   // Accessed value held for the move
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff <= req_key;
      end
   end

   // Row of list positions, front at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value, right_value;

      if (i == 0) begin : g_front
         assign left_value = key_ff;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_value = cell_value[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      mtf_cell #(
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .key         (req_key),
         .left_value  (left_value),
         .right_value (right_value),
         .front_value (cell_value[0]),
         .hit_in      (hit[i]),
         .hit_out     (hit[i+1]),
         .value       (cell_value[i])
      );
   end

   // Sequencer and output stage
   mtf_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .found_in       (hit[CAPACITY]),
      .key_field      (key_field),
      .front_field    (front_field),
      .cell_ctrl      (cell_ctrl),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_entry      (rsp_entry),
      .rsp_is_last    (rsp_is_last),
      .rsp_found      (rsp_found),
      .rsp_dropped    (rsp_dropped),
      .rsp_list_empty (rsp_list_empty)
   );

endmodule
